>>> src/cgs_pkg.sv
`timescale 1ns / 1ps

package cgs_pkg;

  // Field and register widths fixed by the block's interface.
  localparam int COORD_W     = 6;
  localparam int SIZE_REG_W  = 7;
  localparam int PASS_REG_W  = 4;
  localparam int DATA_W      = 7;
  localparam int REG_INDEX_W = 2;

  // Command codes carried in the action field.
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_SMOOTH = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_PASS_COUNT  = 2'd2;

  // Register values after reset.
  localparam logic [SIZE_REG_W-1:0] GRID_WIDTH_RESET  = 7'd64;
  localparam logic [SIZE_REG_W-1:0] GRID_HEIGHT_RESET = 7'd64;
  localparam logic [PASS_REG_W-1:0] PASS_COUNT_RESET  = 4'd5;

  // A neighbour count equal to this leaves the cell unchanged.
  localparam int KEEP_COUNT = 4;

  // Phases of one window step: three column reads, then the update slot.
  localparam logic [1:0] PH_COL0  = 2'd0;
  localparam logic [1:0] PH_COL1  = 2'd1;
  localparam logic [1:0] PH_COL2  = 2'd2;
  localparam logic [1:0] PH_WRITE = 2'd3;

  typedef enum logic [2:0] {
    SM_IDLE,
    SM_PASS,
    SM_COLUMN,
    SM_FETCH,
    SM_DONE
  } smooth_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } smooth_status_t;

endpackage

>>> src/cgs_in_if.sv
`timescale 1ns / 1ps

interface cgs_in_if import cgs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic               cell_value;

  modport source (output valid, action, cell_x, cell_y, cell_value, input ready);
  modport sink   (input valid, action, cell_x, cell_y, cell_value, output ready);
endinterface

>>> src/cgs_out_if.sv
`timescale 1ns / 1ps

interface cgs_out_if import cgs_pkg::*; ();
  logic valid;
  logic ready;
  logic read_value;
  logic out_of_range;

  modport source (output valid, read_value, out_of_range, input ready);
  modport sink   (input valid, read_value, out_of_range, output ready);
endinterface

>>> src/cgs_ram.sv
`timescale 1ns / 1ps

module cgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/cgs_smoother.sv
`timescale 1ns / 1ps

module cgs_smoother import cgs_pkg::*; #(
  parameter int XW = 6,
  parameter int YW = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [XW:0]           used_w,
  input  logic [YW:0]           used_h,
  input  logic [PASS_REG_W-1:0] passes,
  output smooth_status_t        status,
  output logic                  re,
  output logic [XW+YW-1:0]      raddr,
  input  logic                  rdata,
  output logic                  we,
  output logic [XW+YW-1:0]      waddr,
  output logic                  wdata
);

  smooth_state_t state, state_next;

  logic [PASS_REG_W-1:0] pass_idx;
  logic [XW-1:0]         x;
  logic [YW:0]           f;      // row being fetched; the cell updated is f - 1
  logic [1:0]            ph;
  logic                  rd_wall;
  logic [2:0]            row0;   // row f - 2, columns x - 1 .. x + 1
  logic [2:0]            row1;   // row f - 1
  logic [1:0]            row2;   // row f, columns x - 1 and x

  logic [XW:0]   x_plus;
  logic          x_last;
  logic          f_last;
  logic          col_ok;
  logic          row_ok;
  logic [XW-1:0] col_sel;
  logic          issue;
  logic          fetched;
  logic [2:0]    row2_full;
  logic [3:0]    count;
  logic          new_val;
  logic [YW:0]   y_upd;

  assign x_plus = {1'b0, x} + {{XW{1'b0}}, 1'b1};
  assign x_last = (x_plus == used_w);
  assign f_last = (f == used_h);
  assign row_ok = (f < used_h);
  assign y_upd  = f - {{YW{1'b0}}, 1'b1};

  always_comb begin
    case (ph)
      PH_COL0: begin
        col_ok  = (x != '0);
        col_sel = x - {{(XW-1){1'b0}}, 1'b1};
      end
      PH_COL1: begin
        col_ok  = 1'b1;
        col_sel = x;
      end
      PH_COL2: begin
        col_ok  = (x_plus < used_w);
        col_sel = x_plus[XW-1:0];
      end
      default: begin
        col_ok  = 1'b0;
        col_sel = x;
      end
    endcase
  end

  // Neighbours off the grid read as walls without touching the memory.
  assign fetched   = rd_wall | rdata;
  assign row2_full = {fetched, row2};

  assign count = 4'(row0[0]) + 4'(row0[1]) + 4'(row0[2]) + 4'(row1[0]) + 4'(row1[2])
               + 4'(row2_full[0]) + 4'(row2_full[1]) + 4'(row2_full[2]);

  always_comb begin
    if (count > 4'(KEEP_COUNT)) begin
      new_val = 1'b1;
    end else if (count < 4'(KEEP_COUNT)) begin
      new_val = 1'b0;
    end else begin
      new_val = row1[1];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SM_IDLE: begin
        if (start) begin
          state_next = SM_PASS;
        end
      end
      SM_PASS: begin
        state_next = (pass_idx == passes) ? SM_DONE : SM_COLUMN;
      end
      SM_COLUMN: begin
        state_next = SM_FETCH;
      end
      SM_FETCH: begin
        if (ph == PH_WRITE && f_last) begin
          state_next = x_last ? SM_PASS : SM_COLUMN;
        end
      end
      SM_DONE: begin
        state_next = SM_IDLE;
      end
      default: begin
        state_next = SM_IDLE;
      end
    endcase
  end

  always_comb begin
    issue       = (state == SM_FETCH) && (ph != PH_WRITE);
    status.busy = (state != SM_IDLE);
    status.done = (state == SM_DONE);
    re          = issue && col_ok && row_ok;
    raddr       = {col_sel, f[YW-1:0]};
    we          = (state == SM_FETCH) && (ph == PH_WRITE) && (f != '0);
    waddr       = {x, y_upd[YW-1:0]};
    wdata       = new_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SM_IDLE: begin
        pass_idx <= '0;
      end
      SM_PASS: begin
        x <= '0;
      end
      SM_COLUMN: begin
        f    <= '0;
        ph   <= PH_COL0;
        row1 <= 3'b111;
      end
      SM_FETCH: begin
        ph      <= ph + 2'd1;
        rd_wall <= !(col_ok && row_ok);
        if (ph == PH_COL1) begin
          row2[0] <= fetched;
        end
        if (ph == PH_COL2) begin
          row2[1] <= fetched;
        end
        if (ph == PH_WRITE) begin
          row0 <= {row1[2], (f != '0) ? new_val : row1[1], row1[0]};
          row1 <= row2_full;
          f    <= f + {{YW{1'b0}}, 1'b1};
          if (f_last) begin
            x <= x_plus[XW-1:0];
            if (x_last) begin
              pass_idx <= pass_idx + {{(PASS_REG_W-1){1'b0}}, 1'b1};
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  a_no_read_in_write_slot: assert property (@(posedge clk) disable iff (rst)
    we |-> !re)
    else $error("grid read issued in the update slot");

  a_read_row_in_grid: assert property (@(posedge clk) disable iff (rst)
    re |-> (f < used_h))
    else $error("grid read below the last row");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == SM_IDLE))
    else $error("smooth started while a run is in progress");

endmodule

>>> src/cave_grid_smoothing_unit.sv
`timescale 1ns / 1ps

// Cave grid smoothing unit.
// Commands arrive on the cmd channel and each produces exactly one transfer on the
// result channel, in order. A write stores cell_value at (cell_x, cell_y); a read
// returns the stored cell in read_value; either one outside the configured grid is
// ignored and flagged with out_of_range. A smooth command runs pass_count in-place
// passes of the 4-5 neighbour rule and then returns an all-zero result.
// Writes and reads take one transfer per cycle while no smooth run is in progress
// and the receiver keeps up; each result passes through the result stage and then
// the output register. A smooth command's run time is set by the single read
// port of the grid memory: each cell costs three reads of the next row plus one
// slot for the write-back.
// Configuration registers are written through write_enable, reg_index and
// write_data; the user must write them only while the unit is idle, which the
// unit does not enforce; sizes of zero act as one, above the maximum as the maximum.
// Reset returns the registers to 64 by 64 with five passes and empties the result
// stage; the grid contents are not cleared, so every cell must be written before
// it is read or smoothed. While the receiver stalls, one result waits in the
// output register and one more behind it, after which cmd.ready stays low.
module cave_grid_smoothing_unit import cgs_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  cgs_in_if.sink                 cmd,
  cgs_out_if.source              result,
  input  logic                   write_enable,
  input  logic [REG_INDEX_W-1:0] reg_index,
  input  logic [DATA_W-1:0]      write_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  // Compare widths that hold the size registers and the maxima alike.
  localparam int XCW   = (XW + 1 > SIZE_REG_W) ? XW + 1 : SIZE_REG_W;
  localparam int YCW   = (YW + 1 > SIZE_REG_W) ? YW + 1 : SIZE_REG_W;

  logic [SIZE_REG_W-1:0] grid_width;
  logic [SIZE_REG_W-1:0] grid_height;
  logic [PASS_REG_W-1:0] pass_count;

  logic [XCW-1:0] width_ext;
  logic [YCW-1:0] height_ext;
  logic [XCW-1:0] used_w_wide;
  logic [YCW-1:0] used_h_wide;
  logic [XCW-1:0] x_ext;
  logic [YCW-1:0] y_ext;

  logic           in_transfer;
  logic           out_free;
  logic           is_access;
  logic           oor;
  logic           acc_we;
  logic           acc_re;
  logic           smooth_start;
  logic [AW-1:0]  acc_addr;

  // Result stage: the item behind the output register, waiting for read data.
  logic           pend;
  logic           pend_read;
  logic           pend_oor;

  smooth_status_t status;
  logic           sm_re;
  logic           sm_we;
  logic [AW-1:0]  sm_raddr;
  logic [AW-1:0]  sm_waddr;
  logic           sm_wdata;

  logic           ram_we;
  logic           ram_re;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_raddr;
  logic           ram_wdata;
  logic           ram_rdata;

  // Configuration registers keep the bits written; clamping happens on use.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RESET;
      grid_height <= GRID_HEIGHT_RESET;
      pass_count  <= PASS_COUNT_RESET;
    end else if (write_enable) begin
      case (reg_index)
        REG_GRID_WIDTH:  grid_width  <= write_data[SIZE_REG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= write_data[SIZE_REG_W-1:0];
        REG_PASS_COUNT:  pass_count  <= write_data[PASS_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign width_ext  = XCW'(grid_width);
  assign height_ext = YCW'(grid_height);

  always_comb begin
    if (width_ext == '0) begin
      used_w_wide = XCW'(1);
    end else if (width_ext > XCW'(MAX_WIDTH)) begin
      used_w_wide = XCW'(MAX_WIDTH);
    end else begin
      used_w_wide = width_ext;
    end
    if (height_ext == '0) begin
      used_h_wide = YCW'(1);
    end else if (height_ext > YCW'(MAX_HEIGHT)) begin
      used_h_wide = YCW'(MAX_HEIGHT);
    end else begin
      used_h_wide = height_ext;
    end
  end

  // Single cell accesses. The grid is stored column by column, so the address is
  // simply the column index above the row index.
  assign x_ext        = XCW'(cmd.cell_x);
  assign y_ext        = YCW'(cmd.cell_y);
  assign is_access    = (cmd.action == ACT_WRITE) || (cmd.action == ACT_READ);
  assign oor          = is_access && ((x_ext >= used_w_wide) || (y_ext >= used_h_wide));
  assign acc_addr     = {x_ext[XW-1:0], y_ext[YW-1:0]};

  assign out_free     = !result.valid || result.ready;
  assign cmd.ready    = !status.busy && (!pend || out_free);
  assign in_transfer  = cmd.valid && cmd.ready;
  assign acc_we       = in_transfer && (cmd.action == ACT_WRITE) && !oor;
  assign acc_re       = in_transfer && (cmd.action == ACT_READ) && !oor;
  assign smooth_start = in_transfer && (cmd.action == ACT_SMOOTH);

  cgs_smoother #(
    .XW (XW),
    .YW (YW)
  ) u_smoother (
    .clk    (clk),
    .rst    (rst),
    .start  (smooth_start),
    .used_w (used_w_wide[XW:0]),
    .used_h (used_h_wide[YW:0]),
    .passes (pass_count),
    .status (status),
    .re     (sm_re),
    .raddr  (sm_raddr),
    .rdata  (ram_rdata),
    .we     (sm_we),
    .waddr  (sm_waddr),
    .wdata  (sm_wdata)
  );

  // The smoother owns the grid memory for the whole of a run.
  assign ram_we    = status.busy ? sm_we    : acc_we;
  assign ram_re    = status.busy ? sm_re    : acc_re;
  assign ram_waddr = status.busy ? sm_waddr : acc_addr;
  assign ram_raddr = status.busy ? sm_raddr : acc_addr;
  assign ram_wdata = status.busy ? sm_wdata : cmd.cell_value;

  cgs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A smooth command is only taken when the result stage is empty or empties in the
  // same cycle, so the smoother's reads can never disturb read data still waiting.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (in_transfer && !smooth_start) begin
      pend <= 1'b1;
    end else if (status.done) begin
      pend <= 1'b1;
    end else if (out_free) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_transfer && !smooth_start) begin
      pend_read <= acc_re;
      pend_oor  <= oor;
    end else if (status.done) begin
      pend_read <= 1'b0;
      pend_oor  <= 1'b0;
    end
  end

  // Output register: the memory's read data joins the result here.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend) begin
      result.read_value   <= pend_read & ram_rdata;
      result.out_of_range <= pend_oor;
    end
  end

  a_stage_empty_while_busy: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !pend)
    else $error("result stage occupied during a smoothing run");

  a_run_follows_command: assert property (@(posedge clk) disable iff (rst)
    $rose(status.busy) |-> $past(smooth_start))
    else $error("smoothing run began without a smooth command");

  a_result_held_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=>
      (result.valid && $stable(result.read_value) && $stable(result.out_of_range)))
    else $error("waiting result changed before its transfer");

endmodule
